[hw/rtl/rss_pkg.sv]
// Shared constants and the command type of the running sample statistics block.
package rss_pkg;

	localparam logic [15:0] MAX_COUNT = 16'd65535;

	localparam int VAR_STEPS  = 48;
	localparam int MEAN_STEPS = 24;
	localparam int ROOT_STEPS = 24;
	localparam int STEP_W     = 6;

	typedef struct packed {
		logic accept;
		logic mul_a;
		logic mul_b;
		logic mul_c;
		logic div_step;
		logic mean_step;
		logic sqrt_load;
		logic sqrt_step;
		logic fin_load;
	} rss_cmd_t;

endpackage

[hw/rtl/rss_in_if.sv]
// Input channel carrying one add or clear request.
interface rss_in_if;
	logic              valid;
	logic              ready;
	logic              action;
	logic signed [15:0] sample;

	modport source (output valid, output action, output sample, input ready);
	modport sink (input valid, input action, input sample, output ready);
endinterface

[hw/rtl/rss_out_if.sv]
// Output channel carrying one statistics result.
interface rss_out_if;
	logic               valid;
	logic               ready;
	logic        [15:0] count;
	logic signed [31:0] total;
	logic signed [15:0] smallest;
	logic signed [15:0] largest;
	logic signed [23:0] mean_q8;
	logic        [23:0] stdev_q8;
	logic               valid_res;
	logic               dropped;

	modport source (output valid, output count, output total, output smallest,
		output largest, output mean_q8, output stdev_q8, output valid_res,
		output dropped, input ready);
	modport sink (input valid, input count, input total, input smallest,
		input largest, input mean_q8, input stdev_q8, input valid_res,
		input dropped, output ready);
endinterface

[hw/rtl/rss_controller.sv]
// Sequencing state machine of the running sample statistics block.
module rss_controller
	import rss_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output rss_cmd_t cmd
);

	typedef enum logic [7:0] {
		IDLE  = 8'b00000001,
		MUL_A = 8'b00000010,
		MUL_B = 8'b00000100,
		MUL_C = 8'b00001000,
		DIV   = 8'b00010000,
		SQLD  = 8'b00100000,
		SQRT  = 8'b01000000,
		FIN   = 8'b10000000
	} rss_state_t;

	rss_state_t        state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              step_last;
	logic              fin_ok;

	assign fin_ok = !out_valid_q || out_ready;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		step_last = 1'b0;
		case (state_q)
			IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) state_d = MUL_A;
			end
			MUL_A: begin
				cmd.mul_a = 1'b1;
				state_d   = MUL_B;
			end
			MUL_B: begin
				cmd.mul_b = 1'b1;
				state_d   = MUL_C;
			end
			MUL_C: begin
				cmd.mul_c = 1'b1;
				state_d   = DIV;
			end
			DIV: begin
				cmd.div_step  = 1'b1;
				cmd.mean_step = step_q < STEP_W'(MEAN_STEPS);
				step_last     = step_q == STEP_W'(VAR_STEPS - 1);
				if (step_last) state_d = SQLD;
			end
			SQLD: begin
				cmd.sqrt_load = 1'b1;
				state_d       = SQRT;
			end
			SQRT: begin
				cmd.sqrt_step = 1'b1;
				step_last     = step_q == STEP_W'(ROOT_STEPS - 1);
				if (step_last) state_d = FIN;
			end
			FIN: begin
				cmd.fin_load = fin_ok;
				if (fin_ok) state_d = IDLE;
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == DIV || state_q == SQRT) && !step_last) begin
				step_q <= step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end
			if (cmd.fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == IDLE;
	assign out_valid = out_valid_q;

endmodule

[hw/rtl/rss_datapath.sv]
// Accumulators, multipliers, dividers, square root and result register.
module rss_datapath
	import rss_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  rss_cmd_t           cmd,
	input  logic               action,
	input  logic signed [15:0] sample,
	output logic        [15:0] count,
	output logic signed [31:0] total,
	output logic signed [15:0] smallest,
	output logic signed [15:0] largest,
	output logic signed [23:0] mean_q8,
	output logic        [23:0] stdev_q8,
	output logic               valid_res,
	output logic               dropped
);

	logic        [15:0] count_q;
	logic signed [31:0] sum_q;
	logic        [45:0] sxx_q;
	logic signed [15:0] min_q;
	logic signed [15:0] max_q;
	logic               drop_q;

	logic [31:0] mag_q;
	logic        neg_q;
	logic [38:0] plo_q;
	logic [38:0] phi_q;
	logic [63:0] sq_q;
	logic [31:0] d_q;

	logic [31:0] vrem_q;
	logic [47:0] vdiv_q;
	logic [15:0] mrem_q;
	logic [23:0] mdiv_q;

	logic [47:0] sop_q;
	logic [25:0] srem_q;
	logic [23:0] sroot_q;

	logic [31:0] square;
	logic [31:0] mag;
	logic [61:0] mval;
	logic [39:0] smag;
	logic [32:0] vtrial;
	logic        vge;
	logic [16:0] mtrial;
	logic        mge;
	logic [25:0] strial;
	logic [25:0] sshift;
	logic        sge;
	logic [24:0] mean_full;

	assign square = 32'(32'(signed'(sample)) * 32'(signed'(sample)));
	assign mag    = sum_q[31] ? 32'(-sum_q) : 32'(sum_q);

	assign mval = 62'({2'b00, phi_q, 23'b0} + {25'b0, plo_q} - sq_q);
	assign smag = {mag_q, 8'b0};

	assign vtrial = {vrem_q, vdiv_q[47]};
	assign vge    = vtrial >= {1'b0, d_q};
	assign mtrial = {mrem_q, mdiv_q[23]};
	assign mge    = mtrial >= {1'b0, count_q};
	assign sshift = {srem_q[23:0], sop_q[47:46]};
	assign strial = {sroot_q, 2'b01};
	assign sge    = sshift >= strial;

	assign mean_full = neg_q ? 25'(-{1'b0, mdiv_q}) - {24'b0, mrem_q != 16'd0}
		: {1'b0, mdiv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			sxx_q   <= '0;
			min_q   <= '0;
			max_q   <= '0;
			drop_q  <= 1'b0;
		end else if (cmd.accept) begin
			if (action) begin
				count_q <= '0;
				sum_q   <= '0;
				sxx_q   <= '0;
				min_q   <= '0;
				max_q   <= '0;
				drop_q  <= 1'b0;
			end else if (count_q >= MAX_COUNT) begin
				drop_q <= 1'b1;
			end else begin
				count_q <= count_q + 16'd1;
				sum_q   <= sum_q + 32'(sample);
				sxx_q   <= sxx_q + {14'b0, square};
				if (count_q == 16'd0 || sample < min_q) min_q <= sample;
				if (count_q == 16'd0 || sample > max_q) max_q <= sample;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_a) begin
			mag_q <= mag;
			neg_q <= sum_q[31];
			plo_q <= 39'(count_q) * 39'(sxx_q[22:0]);
			d_q   <= 32'(count_q) * 32'(count_q - 16'd1);
		end
		if (cmd.mul_b) begin
			phi_q <= 39'(count_q) * 39'(sxx_q[45:23]);
			sq_q  <= 64'(mag_q) * 64'(mag_q);
		end
		if (cmd.mul_c) begin
			vrem_q <= {2'b00, mval[61:32]};
			vdiv_q <= {mval[31:0], 16'b0};
			mrem_q <= smag[39:24];
			mdiv_q <= smag[23:0];
		end
		if (cmd.div_step) begin
			vrem_q <= vge ? 32'(vtrial - {1'b0, d_q}) : vtrial[31:0];
			vdiv_q <= {vdiv_q[46:0], vge};
		end
		if (cmd.mean_step) begin
			mrem_q <= mge ? 16'(mtrial - {1'b0, count_q}) : mtrial[15:0];
			mdiv_q <= {mdiv_q[22:0], mge};
		end
		if (cmd.sqrt_load) begin
			sop_q   <= vdiv_q;
			srem_q  <= '0;
			sroot_q <= '0;
		end
		if (cmd.sqrt_step) begin
			srem_q  <= sge ? sshift - strial : sshift;
			sroot_q <= {sroot_q[22:0], sge};
			sop_q   <= {sop_q[45:0], 2'b00};
		end
		if (cmd.fin_load) begin
			count     <= count_q;
			total     <= sum_q;
			smallest  <= min_q;
			largest   <= max_q;
			mean_q8   <= (count_q == 16'd0) ? 24'sd0 : signed'(mean_full[23:0]);
			stdev_q8  <= (count_q < 16'd2) ? 24'd0 : sroot_q;
			valid_res <= count_q != 16'd0;
			dropped   <= drop_q;
		end
	end

endmodule

[hw/rtl/running_sample_statistics.sv]
// Top level of the running sample statistics block.
// A request is taken only in the idle state, so no new request is taken until the
// last one is through; the 48-step divider and the 24-step square root run one
// after the other while it is busy.
// Reset clears all accumulators, the dropped flag and the output valid.
// The next request is taken while an earlier result still waits.
module running_sample_statistics
	import rss_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	rss_in_if.sink    samples,
	rss_out_if.source results
);

	rss_cmd_t cmd;

	rss_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd)
	);

	rss_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.action    (samples.action),
		.sample    (samples.sample),
		.count     (results.count),
		.total     (results.total),
		.smallest  (results.smallest),
		.largest   (results.largest),
		.mean_q8   (results.mean_q8),
		.stdev_q8  (results.stdev_q8),
		.valid_res (results.valid_res),
		.dropped   (results.dropped)
	);

endmodule

[verif/running_sample_statistics_tb.sv]
// Self-checking testbench for the running sample statistics block.
`timescale 1ns / 100ps

module running_sample_statistics_tb;

	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	localparam int LATENCY      = 77;
	localparam int STALL_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 800;
	localparam int HOLD_AFTER   = 300;
	localparam int RANDOM_ITEMS = 1400;
	localparam int QUIET_FROM   = 40000;
	localparam int QUIET_TO     = 60000;

	typedef struct {
		logic               action;
		logic signed [15:0] sample;
	} request_t;

	typedef struct {
		logic        [15:0] count;
		logic signed [31:0] total;
		logic signed [15:0] smallest;
		logic signed [15:0] largest;
		logic signed [23:0] mean_q8;
		logic        [23:0] stdev_q8;
		logic               valid_res;
		logic               dropped;
	} stats_t;

	logic clk;
	logic arst_n;

	rss_in_if  req_if ();
	rss_out_if res_if ();

	running_sample_statistics dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (req_if),
		.results (res_if)
	);

	request_t pending_reqs[$];
	stats_t   pending_stats[$];

	logic        [15:0] run_count;
	logic signed [31:0] run_sum;
	logic        [45:0] run_sqsum;
	logic signed [15:0] run_min;
	logic signed [15:0] run_max;
	logic               run_dropped;

	int  mismatches    = 0;
	int  requests_seen = 0;
	int  results_seen  = 0;
	int  clears_seen   = 0;
	int  drops_seen    = 0;
	int  deepest       = 0;
	int  cycle_no      = 0;
	int  stall_cycles  = 0;
	int  hold_left     = 0;
	bit  hold_done     = 1'b0;
	bit  req_taken     = 1'b0;
	bit  quiet;

	assign quiet = (cycle_no >= QUIET_FROM) && (cycle_no < QUIET_TO);

	always #5 clk = ~clk;

	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned rem;
		longint unsigned root;
		longint unsigned probe;
		rem = v;
		root = 0;
		probe = 64'd1 << 62;
		while (probe > rem)
			probe = probe >> 2;
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem = rem - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	task automatic advance_stats(input logic action, input logic signed [15:0] x,
		output stats_t res);
		longint          square;
		longint          scaled_sum;
		longint          cnt;
		longint          quot;
		longint unsigned un;
		longint unsigned sum_sq;
		longint unsigned numer;
		longint unsigned denom;
		longint unsigned whole;
		longint unsigned frac;
		longint unsigned spread;
		if (action == ACT_CLEAR) begin
			run_count = '0;
			run_sum = '0;
			run_sqsum = '0;
			run_min = '0;
			run_max = '0;
			run_dropped = 1'b0;
			clears_seen++;
		end else if (run_count >= rss_pkg::MAX_COUNT) begin
			run_dropped = 1'b1;
			drops_seen++;
		end else begin
			run_count = run_count + 16'd1;
			run_sum = run_sum + x;
			square = longint'(x) * longint'(x);
			run_sqsum = run_sqsum + square[45:0];
			if (run_count == 16'd1 || x < run_min)
				run_min = x;
			if (run_count == 16'd1 || x > run_max)
				run_max = x;
		end
		res.count = run_count;
		res.total = run_sum;
		res.smallest = run_min;
		res.largest = run_max;
		res.mean_q8 = '0;
		res.stdev_q8 = '0;
		res.valid_res = (run_count != 16'd0);
		res.dropped = run_dropped;
		if (run_count != 16'd0) begin
			cnt = longint'(run_count);
			scaled_sum = longint'(run_sum) * 256;
			quot = scaled_sum / cnt;
			if ((scaled_sum % cnt) != 0 && scaled_sum < 0)
				quot = quot - 1;
			res.mean_q8 = quot[23:0];
		end
		if (run_count >= 16'd2) begin
			un = run_count;
			sum_sq = longint'(run_sum) * longint'(run_sum);
			numer = un * run_sqsum - sum_sq;
			denom = un * (un - 1);
			whole = numer / denom;
			frac = numer % denom;
			spread = (whole << 16) + ((frac << 16) / denom);
			res.stdev_q8 = 24'(floor_root(spread));
		end
	endtask

	task automatic report_mismatch(input string what, input logic signed [31:0] got,
		input logic signed [31:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch at result %0d: %s is %0d, expected %0d",
				results_seen, what, got, want);
	endtask

	task automatic push_add(input logic [15:0] v);
		pending_reqs.push_back('{ACT_ADD, v});
	endtask

	task automatic push_clear();
		pending_reqs.push_back('{ACT_CLEAR, 16'h0000});
	endtask

	// Request driver: a new request may go out at the falling edge after the last was taken.
	always @(negedge clk) begin : request_driver
		request_t next_req;
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else if (!req_if.valid || req_taken) begin
			if (pending_reqs.size() != 0 && (quiet || $urandom_range(0, 99) >= 8)) begin
				next_req = pending_reqs.pop_front();
				req_if.valid <= 1'b1;
				req_if.action <= next_req.action;
				req_if.sample <= next_req.sample;
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// The receiver holds off once for a long stretch so that the block backs up.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_if.ready <= 1'b0;
		end else if (!hold_done && results_seen >= HOLD_AFTER) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= quiet || ($urandom_range(0, 99) >= 8);
		end
	end

	always @(posedge clk) begin : channel_monitor
		stats_t want;
		if (arst_n) begin
			cycle_no++;
			if (res_if.valid && res_if.ready) begin
				if (pending_stats.size() == 0) begin
					report_mismatch("unexpected result, count", res_if.count, 0);
				end else begin
					want = pending_stats.pop_front();
					if (res_if.count !== want.count)
						report_mismatch("count", res_if.count, want.count);
					if (res_if.total !== want.total)
						report_mismatch("total", res_if.total, want.total);
					if (res_if.smallest !== want.smallest)
						report_mismatch("smallest", res_if.smallest, want.smallest);
					if (res_if.largest !== want.largest)
						report_mismatch("largest", res_if.largest, want.largest);
					if (res_if.mean_q8 !== want.mean_q8)
						report_mismatch("mean_q8", res_if.mean_q8, want.mean_q8);
					if (res_if.stdev_q8 !== want.stdev_q8)
						report_mismatch("stdev_q8", res_if.stdev_q8, want.stdev_q8);
					if (res_if.valid_res !== want.valid_res)
						report_mismatch("valid_res", res_if.valid_res, want.valid_res);
					if (res_if.dropped !== want.dropped)
						report_mismatch("dropped", res_if.dropped, want.dropped);
				end
				if (res_if.count > deepest)
					deepest = res_if.count;
				results_seen++;
			end
			if (req_if.valid && req_if.ready) begin
				advance_stats(req_if.action, req_if.sample, want);
				pending_stats.push_back(want);
				requests_seen++;
			end
			req_taken <= req_if.valid && req_if.ready;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles < STALL_LIMIT) begin
				stall_cycles <= stall_cycles + 1;
			end else begin
				$display("timeout: no handshake for %0d cycles, %0d results outstanding",
					STALL_LIMIT, pending_stats.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		int pick;
		int offset;
		logic [31:0] raw;
		clk = 1'b0;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.action = ACT_ADD;
		req_if.sample = '0;
		res_if.ready = 1'b0;
		run_count = '0;
		run_sum = '0;
		run_sqsum = '0;
		run_min = '0;
		run_max = '0;
		run_dropped = 1'b0;

		push_clear();
		push_add(16'h7FFF);
		push_add(16'h8000);
		push_add(16'h0000);
		push_add(16'h0001);
		push_add(16'hFFFF);
		push_add(16'h5555);
		push_add(16'hAAAA);
		push_clear();
		repeat (3) push_add(16'h8000);
		push_clear();
		repeat (2) push_add(16'h7FFF);
		push_clear();
		push_clear();
		push_add(16'd100);
		push_add(16'd101);
		push_add(16'hFFF9);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			raw = $urandom();
			if ($urandom_range(0, 99) < 4) begin
				push_clear();
			end else begin
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					push_add(raw[0] ? 16'h7FFF : 16'h8000);
				end else if (pick <= 2) begin
					offset = $urandom_range(0, 64) - 32;
					push_add(offset[15:0]);
				end else begin
					push_add(raw[15:0]);
				end
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || req_if.valid)
			@(posedge clk);
		while (pending_stats.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);

		$display("Checked %0d results from %0d requests, %0d of them clears.",
			results_seen, requests_seen, clears_seen);
		$display("Count reached %0d; %0d samples were dropped at saturation.",
			deepest, drops_seen);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/rss_pkg.sv
hw/rtl/rss_in_if.sv
hw/rtl/rss_out_if.sv
hw/rtl/rss_controller.sv
hw/rtl/rss_datapath.sv
hw/rtl/running_sample_statistics.sv
verif/running_sample_statistics_tb.sv
